// ----- hdl/tod_pkg.sv -----
// Shared types and constants for the tilt orientation debouncer.
// Used by the front, queue, back, top level and checker; depends on nothing.
package tod_pkg;

    localparam int TIME_BITS     = 48;
    localparam int GRAVITY_FIXED = 2510;
    localparam int US_PER_MS     = 1000;

    localparam int CFG_W = 16;
    localparam int SQ_W  = 32;
    localparam int SUM_W = 34;
    localparam int US_W  = 26;

    // Register reset values.
    localparam logic [CFG_W-1:0] ACCEL_TOL_RESET  = CFG_W'(512);
    localparam logic [CFG_W-1:0] GYRO_LIMIT_RESET = CFG_W'(1024);
    localparam logic [CFG_W-1:0] DWELL_RESET      = CFG_W'(500);
    localparam logic [CFG_W-1:0] RATE_RESET       = CFG_W'(1000);

    // Derived values that match the register reset values.
    localparam logic [SUM_W-1:0] ACCEL_LO_RESET =
        SUM_W'((GRAVITY_FIXED - 512) * (GRAVITY_FIXED - 512));
    localparam logic [SUM_W-1:0] ACCEL_HI_RESET =
        SUM_W'((GRAVITY_FIXED + 512) * (GRAVITY_FIXED + 512));
    localparam logic [SUM_W-1:0] GYRO_SQ_RESET  = SUM_W'(1024 * 1024);
    localparam logic [US_W-1:0]  DWELL_US_RESET = US_W'(500 * US_PER_MS);
    localparam logic [US_W-1:0]  RATE_US_RESET  = US_W'(1000 * US_PER_MS);

    typedef logic [TIME_BITS-1:0] stamp_t;

    typedef enum logic [2:0] {
        ORIENT_UNKNOWN    = 3'd0,
        ORIENT_UPRIGHT    = 3'd1,
        ORIENT_TURN_LEFT  = 3'd2,
        ORIENT_INVERTED   = 3'd3,
        ORIENT_TURN_RIGHT = 3'd4
    } orient_t;

    typedef enum logic [1:0] {
        STATUS_READY   = 2'd0,
        STATUS_BUSY    = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_ACCEL_TOL  = 2'd0,
        CFG_GYRO_LIMIT = 2'd1,
        CFG_DWELL      = 2'd2,
        CFG_RATE_LIMIT = 2'd3
    } cfg_index_t;

    // A classified sample as it travels from the front to the back.
    typedef struct packed {
        logic    ok;
        orient_t det;
        logic    stable;
        stamp_t  stamp;
    } item_t;

endpackage

// ----- hdl/tod_front.sv -----
// Front end: accepts samples, classifies the dominant axis and judges stability.
// Depends on tod_pkg.
module tod_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tod_pkg::CFG_W-1:0] accel_tol,
    input  logic [tod_pkg::CFG_W-1:0] gyro_lim,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic                      sample_ok,
    input  logic signed [15:0]        accel_x,
    input  logic signed [15:0]        accel_y,
    input  logic signed [15:0]        accel_z,
    input  logic signed [15:0]        gyro_x,
    input  logic signed [15:0]        gyro_y,
    input  logic signed [15:0]        gyro_z,
    input  tod_pkg::stamp_t           sample_time_us,
    output logic                      item_valid,
    input  logic                      item_ready,
    output tod_pkg::item_t            item
);
    import tod_pkg::*;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] m;
        begin
            // The most negative value maps onto 0x8000, read as unsigned.
            m = v[15] ? 16'(-v) : 16'(v);
            return m;
        end
    endfunction

    logic [15:0] mx, my, mz;
    orient_t     det_in;

    logic             a_valid_reg, a_valid_next;
    logic             ok_reg;
    orient_t          det_reg;
    stamp_t           stamp_reg;
    logic [SQ_W-1:0]  sq_ax_reg, sq_ay_reg, sq_az_reg;
    logic [SQ_W-1:0]  sq_gx_reg, sq_gy_reg, sq_gz_reg;

    logic [SUM_W-1:0] lo_reg, hi_reg, gl2_reg;
    logic [16:0]      g_plus_t, g_minus_t;

    logic [SUM_W-1:0] a2, g2;
    logic             accept, push;

    assign mx = mag16(accel_x);
    assign my = mag16(accel_y);
    assign mz = mag16(accel_z);

    // Z wins ties, then X; a Y-dominant sample is left unclassified.
    always_comb
    begin
        if (mz >= mx && mz >= my)
        begin
            det_in = accel_z[15] ? ORIENT_UPRIGHT : ORIENT_INVERTED;
        end
        else if (mx >= my)
        begin
            det_in = accel_x[15] ? ORIENT_TURN_LEFT : ORIENT_TURN_RIGHT;
        end
        else
        begin
            det_in = ORIENT_UNKNOWN;
        end
    end

    assign push         = a_valid_reg && item_ready;
    assign sample_ready = !a_valid_reg || item_ready;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (push)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= sample_ok;
            det_reg   <= det_in;
            stamp_reg <= sample_time_us;
            sq_ax_reg <= SQ_W'(mx) * SQ_W'(mx);
            sq_ay_reg <= SQ_W'(my) * SQ_W'(my);
            sq_az_reg <= SQ_W'(mz) * SQ_W'(mz);
            sq_gx_reg <= SQ_W'(mag16(gyro_x)) * SQ_W'(mag16(gyro_x));
            sq_gy_reg <= SQ_W'(mag16(gyro_y)) * SQ_W'(mag16(gyro_y));
            sq_gz_reg <= SQ_W'(mag16(gyro_z)) * SQ_W'(mag16(gyro_z));
        end
    end

    // Stability bounds are registered, so they follow the configuration inputs in the next cycle.
    assign g_plus_t  = 17'(GRAVITY_FIXED) + 17'(accel_tol);
    assign g_minus_t = 17'(GRAVITY_FIXED) - 17'(accel_tol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= ACCEL_LO_RESET;
            hi_reg  <= ACCEL_HI_RESET;
            gl2_reg <= GYRO_SQ_RESET;
        end
        else
        begin
            lo_reg  <= (17'(accel_tol) >= 17'(GRAVITY_FIXED)) ? '0 :
                       SUM_W'(g_minus_t) * SUM_W'(g_minus_t);
            hi_reg  <= SUM_W'(g_plus_t) * SUM_W'(g_plus_t);
            gl2_reg <= SUM_W'(gyro_lim) * SUM_W'(gyro_lim);
        end
    end

    assign a2 = SUM_W'(sq_ax_reg) + SUM_W'(sq_ay_reg) + SUM_W'(sq_az_reg);
    assign g2 = SUM_W'(sq_gx_reg) + SUM_W'(sq_gy_reg) + SUM_W'(sq_gz_reg);

    assign item_valid  = a_valid_reg;
    assign item.ok     = ok_reg;
    assign item.det    = det_reg;
    assign item.stable = (a2 >= lo_reg) && (a2 <= hi_reg) && (g2 <= gl2_reg);
    assign item.stamp  = stamp_reg;

endmodule

// ----- hdl/tod_queue.sv -----
// Two-entry queue of classified samples between the front and the back.
// Depends on tod_pkg.
module tod_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tod_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tod_pkg::item_t pop_item
);
    import tod_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/tod_back.sv -----
// Back end: applies the debounce, dwell and rate limit rules and holds the result.
// Depends on tod_pkg.
module tod_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tod_pkg::CFG_W-1:0] dwell_ms,
    input  logic [tod_pkg::CFG_W-1:0] rate_limit_ms,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  tod_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [2:0]                orientation,
    output logic [1:0]                status,
    output logic                      changed,
    output logic [31:0]               suppressed_count,
    output logic [31:0]               published_count,
    output tod_pkg::stamp_t           commit_time_us
);
    import tod_pkg::*;

    logic [US_W-1:0] dwell_us_reg, rate_us_reg;

    orient_t     cur_reg, cur_next;
    orient_t     pend_reg, pend_next;
    stamp_t      since_reg, since_next;
    stamp_t      change_reg, change_next;
    logic        seen_reg, seen_next;
    logic [31:0] sup_reg, sup_next;
    logic [31:0] pub_reg, pub_next;

    logic        out_valid_reg, out_valid_next;
    status_t     status_reg, status_next;
    logic        changed_reg, changed_next;

    stamp_t      dwell_elapsed, rate_elapsed;
    logic        pop;

    assign item_ready = !out_valid_reg || result_ready;
    assign pop        = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_us_reg <= DWELL_US_RESET;
            rate_us_reg  <= RATE_US_RESET;
        end
        else
        begin
            dwell_us_reg <= US_W'(dwell_ms) * US_W'(US_PER_MS);
            rate_us_reg  <= US_W'(rate_limit_ms) * US_W'(US_PER_MS);
        end
    end

    // Elapsed times wrap with the timestamp width.
    assign dwell_elapsed = item.stamp - since_reg;
    assign rate_elapsed  = item.stamp - change_reg;

    always_comb
    begin
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        since_next   = since_reg;
        change_next  = change_reg;
        seen_next    = seen_reg;
        sup_next     = sup_reg;
        pub_next     = pub_reg;
        status_next  = STATUS_READY;
        changed_next = 1'b0;

        if (!item.ok)
        begin
            status_next = STATUS_INVALID;
        end
        else if (item.det == ORIENT_UNKNOWN)
        begin
            // Nothing to do: the current orientation stands.
        end
        else if (item.det == cur_reg)
        begin
            pend_next  = ORIENT_UNKNOWN;
            since_next = '0;
        end
        else if (!item.stable)
        begin
            sup_next    = sup_reg + 32'd1;
            status_next = STATUS_BUSY;
        end
        else if (pend_reg != item.det)
        begin
            pend_next  = item.det;
            since_next = item.stamp;
        end
        else if (dwell_elapsed < TIME_BITS'(dwell_us_reg))
        begin
            // Candidate is still dwelling.
        end
        else if (seen_reg && (rate_elapsed < TIME_BITS'(rate_us_reg)))
        begin
            sup_next    = sup_reg + 32'd1;
            status_next = STATUS_BUSY;
        end
        else
        begin
            cur_next     = pend_reg;
            pend_next    = ORIENT_UNKNOWN;
            since_next   = '0;
            change_next  = item.stamp;
            seen_next    = 1'b1;
            pub_next     = pub_reg + 32'd1;
            changed_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= ORIENT_UNKNOWN;
            pend_reg      <= ORIENT_UNKNOWN;
            since_reg     <= '0;
            change_reg    <= '0;
            seen_reg      <= 1'b0;
            sup_reg       <= '0;
            pub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                cur_reg    <= cur_next;
                pend_reg   <= pend_next;
                since_reg  <= since_next;
                change_reg <= change_next;
                seen_reg   <= seen_next;
                sup_reg    <= sup_next;
                pub_reg    <= pub_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status_next;
            changed_reg <= changed_next;
        end
    end

    // The counters and orientation registers only move on a pop, so they
    // already show the state that belongs to the held result.
    assign result_valid     = out_valid_reg;
    assign orientation      = cur_reg;
    assign status           = status_reg;
    assign changed          = changed_reg;
    assign suppressed_count = sup_reg;
    assign published_count  = pub_reg;
    assign commit_time_us   = change_reg;

endmodule

// ----- hdl/tilt_orientation_debouncer.sv -----
// Tilt orientation debouncer, top level: configuration registers, front, queue, back.
// Depends on tod_pkg, tod_front, tod_queue and tod_back.
// Path: a sample accepted by the front is registered there, then in the queue, then in
// the back's output register, where it stays on the result ports until it is taken.
// Throughput: one sample per cycle while each result is taken, set by the front stage and back update.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears the back's
// orientation, pending, timestamp and counter state; no clearing pass is needed.
module tilt_orientation_debouncer (
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port.
    input  logic                      cfg_write,
    input  logic [1:0]                cfg_index,
    input  logic [tod_pkg::CFG_W-1:0] cfg_data,
    // Sample request channel.
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  logic                      sample_ok,
    input  logic signed [15:0]        accel_x,
    input  logic signed [15:0]        accel_y,
    input  logic signed [15:0]        accel_z,
    input  logic signed [15:0]        gyro_x,
    input  logic signed [15:0]        gyro_y,
    input  logic signed [15:0]        gyro_z,
    input  logic [47:0]               sample_time_us,
    // Result request channel.
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [2:0]                orientation,
    output logic [1:0]                status,
    output logic                      changed,
    output logic [31:0]               suppressed_count,
    output logic [31:0]               published_count,
    output logic [47:0]               commit_time_us
);
    import tod_pkg::*;

    // Configuration registers. Writes are expected only while the block is
    // idle. The derived bounds in the front and back are registered and follow in the next cycle.
    logic [CFG_W-1:0] accel_tol_reg;
    logic [CFG_W-1:0] gyro_lim_reg;
    logic [CFG_W-1:0] dwell_reg;
    logic [CFG_W-1:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_tol_reg <= ACCEL_TOL_RESET;
            gyro_lim_reg  <= GYRO_LIMIT_RESET;
            dwell_reg     <= DWELL_RESET;
            rate_reg      <= RATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ACCEL_TOL:  accel_tol_reg <= cfg_data;
                CFG_GYRO_LIMIT: gyro_lim_reg  <= cfg_data;
                CFG_DWELL:      dwell_reg     <= cfg_data;
                CFG_RATE_LIMIT: rate_reg      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The front registers the six squared magnitudes and the dominant-axis
    // class, then sums and compares them against the stability bounds on the
    // way into the queue.
    logic  front_valid, front_ready;
    item_t front_item;

    tod_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accel_tol      (accel_tol_reg),
        .gyro_lim       (gyro_lim_reg),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample_ok      (sample_ok),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .gyro_x         (gyro_x),
        .gyro_y         (gyro_y),
        .gyro_z         (gyro_z),
        .sample_time_us (sample_time_us),
        .item_valid     (front_valid),
        .item_ready     (front_ready),
        .item           (front_item)
    );

    // The queue lets the front keep taking samples while a result waits
    // downstream, and lets the back drain while the input is idle.
    logic  back_valid, back_ready;
    item_t back_item;

    tod_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    // The back applies the debounce rules one item per cycle while each result is taken, and
    // holds the result in its output register until it is taken.
    tod_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .dwell_ms         (dwell_reg),
        .rate_limit_ms    (rate_reg),
        .item_valid       (back_valid),
        .item_ready       (back_ready),
        .item             (back_item),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .orientation      (orientation),
        .status           (status),
        .changed          (changed),
        .suppressed_count (suppressed_count),
        .published_count  (published_count),
        .commit_time_us   (commit_time_us)
    );

endmodule

// ----- hdl/tod_checker.sv -----
// Port-level checker for the tilt orientation debouncer, with its bind.
// Depends on tod_pkg and the tilt_orientation_debouncer top level.
module tod_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [2:0]  orientation,
    input  logic [1:0]  status,
    input  logic        changed,
    input  logic [31:0] published_count
);
    import tod_pkg::*;

    // A result that is not taken stays on the port unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(orientation) && $stable(status) && $stable(changed))
        else $error("result changed while stalled");

    // A commit always reports ready status.
    a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && changed |-> status == STATUS_READY)
        else $error("commit reported with non-ready status");

    // A commit never lands on the unknown orientation.
    a_commit_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && changed |-> orientation != ORIENT_UNKNOWN)
        else $error("commit to unknown orientation");

    // A commit is never shown with a count of commits of zero.
    a_commit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && changed && published_count == 32'd0 |-> 1'b0)
        else $error("commit without a published count");

endmodule

bind tilt_orientation_debouncer tod_checker u_tod_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .orientation     (orientation),
    .status          (status),
    .changed         (changed),
    .published_count (published_count)
);
